FILE: rtl/dlc_pkg.sv
// dlc_pkg: shared sizes, field widths and state encoding for the distinct label counter.
// Used by distinct_label_counter_unit and distinct_label_counter_unit_test; depends on nothing.
`default_nettype none
package dlc_pkg;
   localparam int SLOTS     = 1024;
   localparam int COLORS    = 1024;
   localparam int SLOT_W    = 10;
   localparam int COLOR_W   = 10;
   localparam int DIST_W    = 11;
   localparam int REQ_W     = 24;
   localparam int RSP_W     = 16;
   localparam int SLOT_AW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int COLOR_AW  = (COLORS > 1) ? $clog2(COLORS) : 1;
   localparam int CNT_W     = $clog2(SLOTS + 1);
   localparam int CLR_DEPTH = (SLOTS > COLORS) ? SLOTS : COLORS;
   localparam int CLR_W     = $clog2(CLR_DEPTH);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_SLOT  = 5'b00100,
      ST_PREV  = 5'b01000,
      ST_NEW   = 5'b10000
   } state_type;
endpackage
`default_nettype wire

FILE: rtl/dlc_ram.sv
// dlc_ram: generic single-write, single-read RAM with registered read data.
// Read during write to the same address returns the old contents. No dependencies.
`default_nettype none
module dlc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic      [WIDTH-1:0]                 rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

FILE: rtl/distinct_label_counter_unit.sv
// distinct_label_counter_unit: tracks slot colors and per-color use counts in two RAMs.
// Depends on dlc_pkg and dlc_ram.
// After accept a request goes through slot read, previous-color count update and
// new-color count update (single-port-pair count RAM); the next one is accepted as
// the response registers, unless output stalls. Reset: synchronous; afterwards a clearing
// pass over max(SLOTS, COLORS) = 1024 addresses zeroes both RAMs, req_tready stays low.
`default_nettype none
module distinct_label_counter_unit (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [dlc_pkg::REQ_W-1:0] req_tdata,  // [9:0] slot_index, [19:10] new_color
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic      [dlc_pkg::RSP_W-1:0] rsp_tdata   // [10:0] distinct_colors
);
   import dlc_pkg::*;

   state_type             st_ff, st_in;
   logic [CLR_W-1:0]      clr_ff, clr_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [COLOR_W-1:0]    color_ff, color_in;
   logic [COLOR_W-1:0]    prev_ff, prev_in;
   logic                  ok_ff, ok_in;
   logic                  fwd_ff, fwd_in;
   logic [CNT_W-1:0]      fwd_val_ff, fwd_val_in;
   logic [DIST_W-1:0]     distinct_ff, distinct_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0]     rsp_data_ff, rsp_data_in;

   logic                  accept, finish, prev_live, color_live;
   logic [COLOR_W-1:0]    slot_rdata;
   logic [CNT_W-1:0]      cnt_rdata, cnt_cur;
   logic                  slot_we, cnt_we;
   logic [SLOT_AW-1:0]    slot_waddr, slot_raddr;
   logic [COLOR_W-1:0]    slot_wdata;
   logic [COLOR_AW-1:0]   cnt_waddr, cnt_raddr;
   logic [CNT_W-1:0]      cnt_wdata;

   dlc_ram #(.WIDTH(COLOR_W), .DEPTH(SLOTS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_addr (slot_raddr),
      .rd_data (slot_rdata)
   );

   dlc_ram #(.WIDTH(CNT_W), .DEPTH(COLORS)) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rdata)
   );

   assign finish     = (st_ff == ST_NEW) && (!rsp_valid_ff || rsp_tready);
   assign req_tready = (st_ff == ST_IDLE) || finish;
   assign accept     = req_tvalid && req_tready;
   assign slot_raddr = SLOT_AW'(req_tdata[SLOT_W-1:0]);
   assign cnt_raddr  = (st_ff == ST_SLOT) ? COLOR_AW'(slot_rdata) : COLOR_AW'(color_ff);
   assign cnt_cur    = fwd_ff ? fwd_val_ff : cnt_rdata;
   assign prev_live  = ok_ff && (prev_ff != '0) && (32'(prev_ff) < COLORS);
   assign color_live = ok_ff && (color_ff != '0);

   always_comb begin
      st_in        = st_ff;
      clr_in       = clr_ff;
      slot_in      = slot_ff;
      color_in     = color_ff;
      prev_in      = prev_ff;
      ok_in        = ok_ff;
      fwd_in       = fwd_ff;
      fwd_val_in   = fwd_val_ff;
      distinct_in  = distinct_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      slot_we      = 1'b0;
      slot_waddr   = SLOT_AW'(slot_ff);
      slot_wdata   = color_ff;
      cnt_we       = 1'b0;
      cnt_waddr    = COLOR_AW'(prev_ff);
      cnt_wdata    = cnt_rdata - CNT_W'(1);

      if (accept) begin
         slot_in  = req_tdata[SLOT_W-1:0];
         color_in = req_tdata[SLOT_W +: COLOR_W];
         ok_in    = (32'(req_tdata[SLOT_W-1:0]) < SLOTS) &&
                    (32'(req_tdata[SLOT_W +: COLOR_W]) < COLORS);
         st_in    = ST_SLOT;
      end

      case (st_ff)
         ST_CLEAR: begin
            slot_we    = 1'b1;
            slot_waddr = SLOT_AW'(clr_ff);
            slot_wdata = '0;
            cnt_we     = 1'b1;
            cnt_waddr  = COLOR_AW'(clr_ff);
            cnt_wdata  = '0;
            clr_in     = clr_ff + CLR_W'(1);
            if (32'(clr_ff) == CLR_DEPTH - 1) begin
               st_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
         end
         ST_SLOT: begin
            prev_in = slot_rdata;
            slot_we = ok_ff;
            st_in   = ST_PREV;
         end
         ST_PREV: begin
            fwd_in = 1'b0;
            if (prev_live && cnt_rdata != '0) begin
               cnt_we     = 1'b1;
               fwd_in     = (prev_ff == color_ff);
               fwd_val_in = cnt_rdata - CNT_W'(1);
               if (cnt_rdata == CNT_W'(1) && distinct_ff != '0) begin
                  distinct_in = distinct_ff - DIST_W'(1);
               end
            end
            st_in = ST_NEW;
         end
         ST_NEW: begin
            if (finish) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = distinct_ff;
               if (color_live) begin
                  cnt_we    = 1'b1;
                  cnt_waddr = COLOR_AW'(color_ff);
                  cnt_wdata = cnt_cur + CNT_W'(1);
                  if (cnt_cur == '0) begin
                     distinct_in = distinct_ff + DIST_W'(1);
                     rsp_data_in = distinct_ff + DIST_W'(1);
                  end
               end
               if (!accept) begin
                  st_in = ST_IDLE;
               end
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_CLEAR;
         clr_ff       <= '0;
         distinct_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         fwd_ff       <= 1'b0;
      end else begin
         st_ff        <= st_in;
         clr_ff       <= clr_in;
         distinct_ff  <= distinct_in;
         rsp_valid_ff <= rsp_valid_in;
         fwd_ff       <= fwd_in;
      end
      slot_ff     <= slot_in;
      color_ff    <= color_in;
      prev_ff     <= prev_in;
      ok_ff       <= ok_in;
      fwd_val_ff  <= fwd_val_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);

   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(st_ff == ST_NEW))
      else $error("response raised outside count update");

   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_CLEAR) |-> !req_tready)
      else $error("request taken during clearing pass");

   a_distinct_bound: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_IDLE) |-> (32'(distinct_ff) < COLORS))
      else $error("distinct total out of range");

   a_accept_starts_slot: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (st_ff == ST_SLOT))
      else $error("accepted request did not start slot read");
endmodule
`default_nettype wire

FILE: bench/distinct_label_counter_unit_test.sv
// distinct_label_counter_unit_test: stream bench for the distinct label counter.
// Drives directed and random slot/color requests; predicts distinct color totals.
// Depends on dlc_pkg and distinct_label_counter_unit.
`timescale 1ns / 1ps

module distinct_label_counter_unit_test;
   import dlc_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int LONG_HOLD   = 300;
   localparam int DRAIN_WAIT  = 10;

   class distinct_color_tracker;
      logic [COLOR_W-1:0] slot_color [SLOTS];
      logic [CNT_W-1:0]   use_count [COLORS];
      logic [DIST_W-1:0]  distinct_total;
      logic [DIST_W-1:0]  expected_totals [$];
      int                 mismatches;

      function new();
         foreach (slot_color[i]) slot_color[i] = '0;
         foreach (use_count[i]) use_count[i] = '0;
         distinct_total = '0;
         mismatches = 0;
      endfunction

      function void note_request(logic [SLOT_W-1:0] slot, logic [COLOR_W-1:0] color);
         logic [COLOR_W-1:0] prev;
         if (int'(slot) < SLOTS && int'(color) < COLORS) begin
            prev = slot_color[slot];
            if (prev != '0 && use_count[prev] != '0) begin
               use_count[prev] = use_count[prev] - 1'b1;
               if (use_count[prev] == '0 && distinct_total != '0)
                  distinct_total = distinct_total - 1'b1;
            end
            // color zero uncolors the slot and is never counted
            if (color != '0) begin
               if (use_count[color] == '0)
                  distinct_total = distinct_total + 1'b1;
               use_count[color] = use_count[color] + 1'b1;
            end
            slot_color[slot] = color;
         end
         expected_totals.push_back(distinct_total);
      endfunction

      function void check_response(logic [DIST_W-1:0] got);
         logic [DIST_W-1:0] want;
         if (expected_totals.size() == 0) begin
            $error("distinct_colors: no request pending, actual %0d", got);
            mismatches++;
         end else begin
            want = expected_totals.pop_front();
            if (got !== want) begin
               $error("distinct_colors: expected %0d, actual %0d", want, got);
               mismatches++;
            end
         end
      endfunction

      function int pending();
         return expected_totals.size();
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;

   bit idle_enable = 1'b1;
   bit hold_request = 1'b0;

   distinct_color_tracker tracker = new();

   distinct_label_counter_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      if (!idle_enable) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 50);
   endfunction

   task automatic send_request(input logic [SLOT_W-1:0] slot, input logic [COLOR_W-1:0] color);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W - SLOT_W - COLOR_W){1'b0}}, color, slot};
      do @(posedge clock); while (!req_tready);
      tracker.note_request(slot, color);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   task automatic run_phase(input int count, input int slot_span, input int color_span,
                            input bit idle);
      idle_enable = idle;
      repeat (count)
         send_request(SLOT_W'($urandom_range(0, slot_span - 1)),
                      COLOR_W'($urandom_range(0, color_span - 1)));
   endtask

   // response side: random stalls, plus a long hold when asked
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            stall = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
            stall = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_response(rsp_tdata[DIST_W-1:0]);
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, shared colors, same color again, uncoloring
      send_request(10'd0, 10'd1);
      send_request(10'd1023, 10'd1023);
      send_request(10'd0, 10'd1);
      send_request(10'd1, 10'd1);
      send_request(10'd0, 10'd0);
      send_request(10'd1, 10'd0);
      send_request(10'd5, 10'd0);
      send_request(10'd1023, 10'd1023);
      send_request(10'd1023, 10'd512);
      send_request(10'd682, 10'd341);
      send_request(10'd341, 10'd682);
      send_request(10'd682, 10'd682);
      send_request(10'd341, 10'd0);
      send_request(10'd1023, 10'd0);
      send_request(10'd2, 10'd1023);
      send_request(10'd3, 10'd1023);
      send_request(10'd2, 10'd1);
      wait_drained();

      run_phase(300, 16, 8, 1'b1);
      wait_drained();

      // back-to-back requests against a long response hold
      hold_request = 1'b1;
      run_phase(40, 32, 16, 1'b0);
      wait_drained();

      run_phase(300, SLOTS, COLORS, 1'b1);
      wait_drained();

      run_phase(300, 64, 32, 1'b0);
      wait_drained();

      run_phase(350, SLOTS, COLORS, 1'b1);
      wait_drained();

      repeat (DRAIN_WAIT) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

FILE: distinct_label_counter_unit.f
rtl/dlc_pkg.sv
rtl/dlc_ram.sv
rtl/distinct_label_counter_unit.sv
bench/distinct_label_counter_unit_test.sv
